>>> hdl/srecord_line_parser_top_macros.svh
// Assertion macros for the S-record line parser checker.
`ifndef SRECORD_LINE_PARSER_TOP_MACROS_SVH
`define SRECORD_LINE_PARSER_TOP_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define SRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property at every clock edge, reset included.
`define SRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hdl/srp_pkg.sv
// Shared types and constants of the S-record line parser.
`timescale 1ns / 1ps
package srp_pkg;

  localparam int unsigned TokDepth = 2;
  localparam int unsigned OutDepth = 2;

  localparam logic [2:0] StPass    = 3'd0;
  localparam logic [2:0] StCsumErr = 3'd1;
  localparam logic [2:0] StFStart  = 3'd2;
  localparam logic [2:0] StFEnd    = 3'd3;
  localparam logic [2:0] StNotS    = 3'd4;
  localparam logic [2:0] StShort   = 3'd5;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef struct packed {
    logic [7:0] in_char;
    logic       first_of_line;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] data_word;
    logic [6:0]  word_index;
    logic [31:0] record_address;
    logic [2:0]  status;
    logic [6:0]  word_count;
  } out_item_t;

  typedef struct packed {
    logic       first;
    logic       is_s;
    logic [7:0] type_val;
    logic [7:0] nib_val;
  } token_t;

endpackage

>>> hdl/srp_fifo.sv
// Small register queue with a given width and depth (depth of two or more).
`timescale 1ns / 1ps
module srp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/srp_front.sv
// Front end: decodes each character into a token and queues it for the back end.
`timescale 1ns / 1ps
module srp_front #(
  parameter int unsigned TokDepth = srp_pkg::TokDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  srp_pkg::in_item_t in_item_i,
  input  logic              tok_pop_i,
  output logic              tok_valid_o,
  output srp_pkg::token_t   tok_o
);
  import srp_pkg::*;

  token_t tok_in;
  logic   tok_empty;
  logic   is_digit;

  always_comb begin
    is_digit        = (in_item_i.in_char inside {[8'h30:8'h39]});
    tok_in.first    = in_item_i.first_of_line;
    tok_in.is_s     = (in_item_i.in_char == 8'h53);
    tok_in.type_val = in_item_i.in_char - 8'h30;
    tok_in.nib_val  = is_digit ? (in_item_i.in_char - 8'h30)
                               : (in_item_i.in_char - 8'h41 + 8'd10);
  end

  srp_fifo #(
    .Width($bits(token_t)),
    .Depth(TokDepth)
  ) u_tok_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(tok_in),
    .pop_i  (tok_pop_i),
    .rdata_o(tok_o),
    .full_o (full),
    .empty_o(tok_empty)
  );

  assign tok_valid_o = !tok_empty;

endmodule

>>> hdl/srp_back.sv
// Back end: record state machine that builds words and status items, plus the result queue.
`timescale 1ns / 1ps
module srp_back #(
  parameter int unsigned OutDepth = srp_pkg::OutDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  srp_pkg::token_t    tok_i,
  output logic               tok_pop_o,
  output logic               empty,
  input  logic               pop,
  output srp_pkg::out_item_t out_item_o
);
  import srp_pkg::*;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhType = 3'd1;
  localparam logic [2:0] PhLen  = 3'd2;
  localparam logic [2:0] PhAddr = 3'd3;
  localparam logic [2:0] PhData = 3'd4;
  localparam logic [2:0] PhCsum = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hi_q, hi_d;
  logic        tog_q, tog_d;
  logic [7:0]  pend_q, pend_d;
  logic        bpend_q, bpend_d;
  logic [2:0]  abl_q, abl_d;
  logic [7:0]  dbl_q, dbl_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  sum_q, sum_d;
  logic [6:0]  wc_q, wc_d;

  logic        out_full;
  logic        res_valid;
  out_item_t   res;
  logic [7:0]  byte_val;
  logic [3:0]  need;
  logic [7:0]  dbl_m1;
  logic        emit;
  logic [15:0] word;

  assign tok_pop_o = tok_valid_i && !out_full;

  always_comb begin
    phase_d   = phase_q;
    hi_d      = hi_q;
    tog_d     = tog_q;
    pend_d    = pend_q;
    bpend_d   = bpend_q;
    abl_d     = abl_q;
    dbl_d     = dbl_q;
    addr_d    = addr_q;
    sum_d     = sum_q;
    wc_d      = wc_q;
    res_valid = 1'b0;
    res       = '0;
    emit      = 1'b0;
    word      = '0;
    byte_val  = {hi_q, 4'b0000} + tok_i.nib_val;
    need      = {1'b0, abl_q} + 4'd1;
    dbl_m1    = dbl_q - 8'd1;

    if (tok_pop_o) begin
      if (tok_i.first) begin
        hi_d    = '0;
        tog_d   = 1'b0;
        pend_d  = '0;
        bpend_d = 1'b0;
        abl_d   = '0;
        dbl_d   = '0;
        addr_d  = '0;
        sum_d   = '0;
        wc_d    = '0;
        if (!tok_i.is_s) begin
          phase_d    = PhIdle;
          res_valid  = 1'b1;
          res.kind   = KindStatus;
          res.status = StNotS;
        end else begin
          phase_d = PhType;
        end
      end else begin
        case (phase_q)
          PhIdle: begin
          end
          PhType: begin
            if (tok_i.type_val == 8'd0) begin
              phase_d   = PhIdle;
              res_valid = 1'b1;
              res       = '{kind: KindStatus, data_word: '0, word_index: '0,
                            record_address: addr_q, status: StFStart, word_count: wc_q};
            end else if (tok_i.type_val > 8'd6) begin
              phase_d   = PhIdle;
              res_valid = 1'b1;
              res       = '{kind: KindStatus, data_word: '0, word_index: '0,
                            record_address: addr_q, status: StFEnd, word_count: wc_q};
            end else begin
              abl_d   = tok_i.type_val[2:0] + 3'd1;
              phase_d = PhLen;
            end
          end
          default: begin
            if (!tog_q) begin
              hi_d  = tok_i.nib_val[3:0];
              tog_d = 1'b1;
            end else begin
              tog_d = 1'b0;
              case (phase_q)
                PhLen: begin
                  sum_d = byte_val;
                  if (byte_val < {4'd0, need}) begin
                    phase_d   = PhIdle;
                    res_valid = 1'b1;
                    res       = '{kind: KindStatus, data_word: '0, word_index: '0,
                                  record_address: addr_q, status: StShort,
                                  word_count: wc_q};
                  end else begin
                    dbl_d   = byte_val - {4'd0, need};
                    phase_d = PhAddr;
                  end
                end
                PhAddr: begin
                  addr_d = {addr_q[23:0], byte_val};
                  sum_d  = sum_q + byte_val;
                  abl_d  = abl_q - 3'd1;
                  if (abl_q == 3'd1) begin
                    phase_d = (dbl_q != 8'd0) ? PhData : PhCsum;
                  end
                end
                PhData: begin
                  sum_d = sum_q + byte_val;
                  dbl_d = dbl_m1;
                  if (!bpend_q) begin
                    if (dbl_m1 != 8'd0) begin
                      pend_d  = byte_val;
                      bpend_d = 1'b1;
                    end else begin
                      word = {byte_val, 8'hFF};
                      emit = 1'b1;
                    end
                  end else begin
                    word    = {pend_q, byte_val};
                    bpend_d = 1'b0;
                    pend_d  = '0;
                    emit    = 1'b1;
                  end
                  if (emit) begin
                    if (dbl_m1 == 8'd0) begin
                      phase_d = PhCsum;
                    end
                    res_valid = 1'b1;
                    res       = '{kind: KindData, data_word: word, word_index: wc_q,
                                  record_address: addr_q, status: StPass,
                                  word_count: '0};
                    wc_d      = wc_q + 7'd1;
                  end
                end
                PhCsum: begin
                  phase_d   = PhIdle;
                  res_valid = 1'b1;
                  res       = '{kind: KindStatus, data_word: '0, word_index: '0,
                                record_address: addr_q,
                                status: ((sum_q + byte_val) == 8'hFF) ? StPass : StCsumErr,
                                word_count: wc_q};
                end
                default: begin
                  phase_d = PhIdle;
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      hi_q    <= '0;
      tog_q   <= 1'b0;
      pend_q  <= '0;
      bpend_q <= 1'b0;
      abl_q   <= '0;
      dbl_q   <= '0;
      addr_q  <= '0;
      sum_q   <= '0;
      wc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
      tog_q   <= tog_d;
      pend_q  <= pend_d;
      bpend_q <= bpend_d;
      abl_q   <= abl_d;
      dbl_q   <= dbl_d;
      addr_q  <= addr_d;
      sum_q   <= sum_d;
      wc_q    <= wc_d;
    end
  end

  srp_fifo #(
    .Width($bits(out_item_t)),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .wdata_i(res),
    .pop_i  (pop),
    .rdata_o(out_item_o),
    .full_o (out_full),
    .empty_o(empty)
  );

endmodule

>>> hdl/srecord_line_parser_top.sv
// Top level of the S-record line parser.
//
// The block takes one ASCII character of an S-record line per item on a
// queue-style input: an item is taken at a clock edge with push high and
// full low, and first_of_line marks the first character of a line.
// Results leave through a queue-style output: while empty is low the oldest
// result is on out_item_o, and it is taken at an edge with pop high.
// A result is either a 16-bit data word or a record status item.
// An accepted character is written into the token queue; the record state
// machine pops it from there and pushes its result, if any, to the result
// queue. One character is taken every cycle while full is low, a rate set
// by the back end, consuming one token per cycle while out_full is low.
// Reset empties both internal queues and returns the parser to idle, waiting
// for a line start. When the receiver stalls, the result queue fills, the
// state machine holds, and then the token queue fills and full rises.
`timescale 1ns / 1ps
module srecord_line_parser_top #(
  parameter int unsigned TokDepth = srp_pkg::TokDepth,
  parameter int unsigned OutDepth = srp_pkg::OutDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  srp_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output srp_pkg::out_item_t out_item_o
);
  import srp_pkg::*;

  logic   tok_valid;
  logic   tok_pop;
  token_t tok;

  srp_front #(
    .TokDepth(TokDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .tok_pop_i  (tok_pop),
    .tok_valid_o(tok_valid),
    .tok_o      (tok)
  );

  srp_back #(
    .OutDepth(OutDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_valid_i(tok_valid),
    .tok_i      (tok),
    .tok_pop_o  (tok_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

>>> hdl/srp_checker.sv
// Port-level checker of the S-record line parser and its bind statement.
`timescale 1ns / 1ps
`include "srecord_line_parser_top_macros.svh"
module srp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input srp_pkg::in_item_t  in_item_i,
  input logic               empty,
  input logic               pop,
  input srp_pkg::out_item_t out_item_o
);
  import srp_pkg::*;

  `SRP_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |-> empty, "result shown during reset")
  `SRP_ASSERT(a_status_fields, !empty && out_item_o.kind == KindStatus |-> out_item_o.data_word == 16'd0 && out_item_o.word_index == 7'd0 && (out_item_o.status == StPass || out_item_o.status == StCsumErr || out_item_o.status == StFStart || out_item_o.status == StFEnd || out_item_o.status == StNotS || out_item_o.status == StShort), "bad status item")
  `SRP_ASSERT(a_data_fields, !empty && out_item_o.kind == KindData |-> out_item_o.status == StPass && out_item_o.word_count == 7'd0, "bad data item")
  `SRP_ASSERT(a_not_s_clean, !empty && out_item_o.status == StNotS && out_item_o.kind == KindStatus |-> out_item_o.record_address == 32'd0 && out_item_o.word_count == 7'd0, "line reject carries record data")
  `SRP_ASSERT(a_hold_stalled, !empty && !pop |=> !empty && $stable(out_item_o), "stalled result changed")

endmodule

bind srecord_line_parser_top srp_checker u_srp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .push      (push),
  .full      (full),
  .in_item_i (in_item_i),
  .empty     (empty),
  .pop       (pop),
  .out_item_o(out_item_o)
);
